### src/buddy_page_allocator_assert.svh
// assertion macros for the buddy page allocator
// expects clk and arst_n in the scope where they are used
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
`define BPA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buddy page allocator assertion failed");
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buddy page allocator assertion failed");
`else
`define BPA_ASSERT_IMPL(lbl, ante, cons)
`define BPA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/bpa_pkg.sv
// shared types and constants of the buddy page allocator
// no dependencies
package bpa_pkg;

	localparam int TREE_LEVELS_DEF = 11;
	localparam int PAGE_SHIFT_DEF  = 12;
	localparam int MAX_PAGES_DEF   = 1024;

	localparam int ADDR_W  = 40;
	localparam int COUNT_W = 12;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_COUNT = 2'd1;
	localparam logic [1:0] ST_NO_MEM    = 2'd2;
	localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

	// node flags: bit0 valid, bit1 split, bit2 allocated
	localparam int FLAG_VALID = 0;
	localparam int FLAG_SPLIT = 1;
	localparam int FLAG_ALLOC = 2;

	localparam logic [2:0] NODE_EMPTY = 3'b000;
	localparam logic [2:0] NODE_FREE  = 3'b001;
	localparam logic [2:0] NODE_SPLIT = 3'b011;
	localparam logic [2:0] NODE_USED  = 3'b101;

	typedef struct packed {
		logic               func;
		logic [COUNT_W-1:0] page_count;
		logic [ADDR_W-1:0]  free_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] block_addr;
		logic [1:0]        status;
	} rsp_t;

endpackage

### src/bpa_node_ram.sv
// node flag memory, one write port and one registered read port
// depends on nothing
module bpa_node_ram #(
	parameter int ADDR_W = 11,
	parameter int DEPTH  = 2047
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [2:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [2:0]        rdata
);

	logic [2:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/bpa_ctrl.sv
// sequencer for allocate search, split, free walk and merge
// depends on bpa_pkg and buddy_page_allocator_assert.svh
`include "buddy_page_allocator_assert.svh"

module bpa_ctrl #(
	parameter int TREE_LEVELS = bpa_pkg::TREE_LEVELS_DEF,
	parameter int PAGE_SHIFT  = bpa_pkg::PAGE_SHIFT_DEF,
	parameter int MAX_PAGES   = bpa_pkg::MAX_PAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  bpa_pkg::req_t              req,
	input  logic [bpa_pkg::ADDR_W-1:0] ram_base,
	output logic                       res_valid,
	input  logic                       res_ready,
	output bpa_pkg::rsp_t              res,
	output logic                       mem_we,
	output logic [TREE_LEVELS-1:0]     mem_waddr,
	output logic [2:0]                 mem_wdata,
	output logic [TREE_LEVELS-1:0]     mem_raddr,
	input  logic [2:0]                 mem_rdata
);

	localparam int NODE_W     = TREE_LEVELS;
	localparam int IDX_W      = TREE_LEVELS - 1;
	localparam int LVL_W      = $clog2(TREE_LEVELS);
	localparam int REGION_W   = TREE_LEVELS - 1 + PAGE_SHIFT;
	localparam int NODE_COUNT = 2 ** TREE_LEVELS - 1;
	localparam int AW         = bpa_pkg::ADDR_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_START, S_A_SCAN, S_A_SPLIT, S_A_LEFT, S_A_RIGHT,
		S_F_START, S_F_CHECK, S_F_WAIT, S_F_FREE, S_F_BUD, S_F_ZME, S_RESULT
	} state_t;

	state_t            state_q;
	logic [NODE_W-1:0] clr_q;
	logic              bad_q;
	logic [3:0]        k_q;
	logic [AW-1:0]     off_q;
	logic [LVL_W-1:0]  target_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LVL_W-1:0]  iss_lvl_q;
	logic [IDX_W-1:0]  iss_idx_q;
	logic              iss_done_q;
	logic [LVL_W-1:0]  p_lvl_s1;
	logic [IDX_W-1:0]  p_idx_s1;
	logic              p_vld_s1;
	bpa_pkg::rsp_t     res_q;

	logic [11:0]       pm1;
	logic [3:0]        k;
	logic              bad;
	logic [5:0]        sh;
	logic [AW-1:0]     blk_mask;
	logic [AW-1:0]     blk_off;
	logic              iss_last;
	logic              rd_free;
	logic              rd_busy;

	function automatic logic [NODE_W-1:0] node_addr(input logic [LVL_W-1:0] lvl,
		input logic [IDX_W-1:0] idx);
		logic [NODE_W-1:0] base;
		base = (NODE_W'(1) << lvl) - NODE_W'(1);
		return base + NODE_W'(idx);
	endfunction

	// rounded size exponent of the page count, and the bad-count check
	always_comb begin
		pm1 = req.page_count - 12'd1;
		k   = 4'd0;
		for (int i = 0; i < 12; i++) begin
			if (pm1[i]) begin
				k = 4'(i + 1);
			end
		end
		bad = (req.page_count == '0) || (32'(req.page_count) > MAX_PAGES) ||
			(32'(k) > TREE_LEVELS - 1);
	end

	assign sh       = 6'(REGION_W) - 6'(lvl_q);
	assign blk_mask = (AW'(1) << sh) - AW'(1);
	assign blk_off  = AW'(idx_q) << sh;
	assign iss_last = ({1'b0, iss_idx_q} == ((IDX_W'(1) + {IDX_W{1'b0}}) == '0 ? '0 :
		(((IDX_W + 1)'(1) << iss_lvl_q) - (IDX_W + 1)'(1))));
	assign rd_free  = mem_rdata[bpa_pkg::FLAG_VALID] & ~mem_rdata[bpa_pkg::FLAG_SPLIT] &
		~mem_rdata[bpa_pkg::FLAG_ALLOC];
	assign rd_busy  = mem_rdata[bpa_pkg::FLAG_SPLIT] | mem_rdata[bpa_pkg::FLAG_ALLOC];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = bpa_pkg::NODE_EMPTY;
		mem_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == '0) ? bpa_pkg::NODE_FREE : bpa_pkg::NODE_EMPTY;
			end
			S_A_SCAN: begin
				mem_raddr = node_addr(iss_lvl_q, iss_idx_q);
			end
			S_A_SPLIT: begin
				mem_we    = 1'b1;
				mem_waddr = node_addr(lvl_q, idx_q);
				mem_wdata = (lvl_q == target_q) ? bpa_pkg::NODE_USED : bpa_pkg::NODE_SPLIT;
			end
			S_A_LEFT: begin
				mem_we    = 1'b1;
				mem_waddr = node_addr(lvl_q + LVL_W'(1), idx_q << 1);
				mem_wdata = bpa_pkg::NODE_FREE;
			end
			S_A_RIGHT: begin
				mem_we    = 1'b1;
				mem_waddr = node_addr(lvl_q + LVL_W'(1), (idx_q << 1) | IDX_W'(1));
				mem_wdata = bpa_pkg::NODE_FREE;
			end
			S_F_CHECK: begin
				mem_raddr = node_addr(lvl_q, idx_q);
			end
			S_F_FREE: begin
				mem_we    = 1'b1;
				mem_waddr = node_addr(lvl_q, idx_q);
				mem_wdata = bpa_pkg::NODE_FREE;
				mem_raddr = node_addr(lvl_q, idx_q ^ IDX_W'(1));
			end
			S_F_BUD: begin
				mem_we    = ~rd_busy;
				mem_waddr = node_addr(lvl_q, idx_q ^ IDX_W'(1));
				mem_wdata = bpa_pkg::NODE_EMPTY;
			end
			S_F_ZME: begin
				mem_we    = 1'b1;
				mem_waddr = node_addr(lvl_q, idx_q);
				mem_wdata = bpa_pkg::NODE_EMPTY;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			p_vld_s1   <= 1'b0;
			iss_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (32'(clr_q) == NODE_COUNT - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						bad_q   <= bad;
						k_q     <= k;
						off_q   <= req.free_addr - ram_base;
						state_q <= (req.func == bpa_pkg::FUNC_FREE) ? S_F_START : S_A_START;
					end
				end
				S_A_START: begin
					if (bad_q) begin
						res_q   <= '{block_addr: '0, status: bpa_pkg::ST_BAD_COUNT};
						state_q <= S_RESULT;
					end else begin
						target_q   <= LVL_W'(TREE_LEVELS - 1 - int'(k_q));
						iss_lvl_q  <= LVL_W'(TREE_LEVELS - 1 - int'(k_q));
						iss_idx_q  <= '0;
						iss_done_q <= 1'b0;
						p_vld_s1   <= 1'b0;
						state_q    <= S_A_SCAN;
					end
				end
				S_A_SCAN: begin
					p_vld_s1 <= ~iss_done_q;
					p_lvl_s1 <= iss_lvl_q;
					p_idx_s1 <= iss_idx_q;
					if (!iss_done_q) begin
						if (iss_last) begin
							if (iss_lvl_q == '0) begin
								iss_done_q <= 1'b1;
							end else begin
								iss_lvl_q <= iss_lvl_q - LVL_W'(1);
								iss_idx_q <= '0;
							end
						end else begin
							iss_idx_q <= iss_idx_q + IDX_W'(1);
						end
					end
					if (p_vld_s1 && rd_free) begin
						lvl_q   <= p_lvl_s1;
						idx_q   <= p_idx_s1;
						state_q <= S_A_SPLIT;
					end else if (iss_done_q && !p_vld_s1) begin
						res_q   <= '{block_addr: '0, status: bpa_pkg::ST_NO_MEM};
						state_q <= S_RESULT;
					end
				end
				S_A_SPLIT: begin
					if (lvl_q == target_q) begin
						res_q   <= '{block_addr: ram_base + blk_off, status: bpa_pkg::ST_OK};
						state_q <= S_RESULT;
					end else begin
						state_q <= S_A_LEFT;
					end
				end
				S_A_LEFT: begin
					state_q <= S_A_RIGHT;
				end
				S_A_RIGHT: begin
					lvl_q   <= lvl_q + LVL_W'(1);
					idx_q   <= idx_q << 1;
					state_q <= S_A_SPLIT;
				end
				S_F_START: begin
					if (off_q[AW-1:REGION_W] != '0) begin
						res_q   <= '{block_addr: '0, status: bpa_pkg::ST_BAD_ADDR};
						state_q <= S_RESULT;
					end else begin
						lvl_q   <= LVL_W'(TREE_LEVELS - 1);
						idx_q   <= off_q[PAGE_SHIFT +: IDX_W];
						state_q <= S_F_CHECK;
					end
				end
				S_F_CHECK: begin
					if ((off_q & blk_mask) != '0) begin
						res_q   <= '{block_addr: '0, status: bpa_pkg::ST_BAD_ADDR};
						state_q <= S_RESULT;
					end else begin
						state_q <= S_F_WAIT;
					end
				end
				S_F_WAIT: begin
					if (mem_rdata[bpa_pkg::FLAG_VALID]) begin
						if (mem_rdata[bpa_pkg::FLAG_SPLIT] || !mem_rdata[bpa_pkg::FLAG_ALLOC]) begin
							res_q   <= '{block_addr: '0, status: bpa_pkg::ST_BAD_ADDR};
							state_q <= S_RESULT;
						end else begin
							state_q <= S_F_FREE;
						end
					end else if (lvl_q == '0) begin
						res_q   <= '{block_addr: '0, status: bpa_pkg::ST_BAD_ADDR};
						state_q <= S_RESULT;
					end else begin
						lvl_q   <= lvl_q - LVL_W'(1);
						idx_q   <= idx_q >> 1;
						state_q <= S_F_CHECK;
					end
				end
				S_F_FREE: begin
					if (lvl_q == '0) begin
						res_q   <= '{block_addr: '0, status: bpa_pkg::ST_OK};
						state_q <= S_RESULT;
					end else begin
						state_q <= S_F_BUD;
					end
				end
				S_F_BUD: begin
					if (rd_busy) begin
						res_q   <= '{block_addr: '0, status: bpa_pkg::ST_OK};
						state_q <= S_RESULT;
					end else begin
						state_q <= S_F_ZME;
					end
				end
				S_F_ZME: begin
					lvl_q   <= lvl_q - LVL_W'(1);
					idx_q   <= idx_q >> 1;
					state_q <= S_F_FREE;
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

	`BPA_ASSERT_IMPL(a_waddr_range, mem_we, 32'(mem_waddr) < NODE_COUNT)
	`BPA_ASSERT_IMPL(a_err_zero_addr, res_valid && res.status != bpa_pkg::ST_OK, res.block_addr == '0)
	`BPA_ASSERT_NEXT(a_req_leaves_idle, req_valid && req_ready, state_q != S_IDLE)

endmodule

### src/buddy_page_allocator.sv
// Binary buddy page allocator. After reset a clearing pass initialises all
// 2^TREE_LEVELS - 1 nodes of the node flag memory; no request is taken meanwhile,
// configuration is. An allocate reads one node per cycle from the wanted level
// upwards until a free node turns up, then splits it level by level down to the
// wanted level. A free walks up from the leaf level to the node that holds the block,
// then frees it and merges it with each free buddy on the way up. Both go through the
// single node memory and its registered read port. One request is in work at a time;
// a finished response waits in the output register while the next is taken.
// depends on bpa_pkg, bpa_ctrl, bpa_node_ram and buddy_page_allocator_assert.svh
`include "buddy_page_allocator_assert.svh"

module buddy_page_allocator #(
	parameter int TREE_LEVELS = bpa_pkg::TREE_LEVELS_DEF,
	parameter int PAGE_SHIFT  = bpa_pkg::PAGE_SHIFT_DEF,
	parameter int MAX_PAGES   = bpa_pkg::MAX_PAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bpa_pkg::ADDR_W-1:0] cfg_data,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  bpa_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output bpa_pkg::rsp_t              rsp
);

	logic [bpa_pkg::ADDR_W-1:0] ram_base_q;
	logic                       rsp_valid_q;
	bpa_pkg::rsp_t              rsp_q;
	logic                       res_valid;
	logic                       res_ready;
	bpa_pkg::rsp_t              res;
	logic                       mem_we;
	logic [TREE_LEVELS-1:0]     mem_waddr;
	logic [2:0]                 mem_wdata;
	logic [TREE_LEVELS-1:0]     mem_raddr;
	logic [2:0]                 mem_rdata;

	assign cfg_ready = 1'b1;
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_base_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				ram_base_q <= cfg_data;
			end
			if (res_ready) begin
				rsp_valid_q <= res_valid;
				if (res_valid) begin
					rsp_q <= res;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	bpa_ctrl #(
		.TREE_LEVELS(TREE_LEVELS),
		.PAGE_SHIFT (PAGE_SHIFT),
		.MAX_PAGES  (MAX_PAGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.ram_base (ram_base_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	bpa_node_ram #(
		.ADDR_W(TREE_LEVELS),
		.DEPTH (2 ** TREE_LEVELS - 1)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	`BPA_ASSERT_NEXT(a_res_to_rsp, res_valid && res_ready, rsp_valid)

endmodule

### tb/tb.sv
// testbench for buddy_page_allocator: random and directed allocate/free requests,
// responses checked against a behavioural buddy tree model held here
// depends on bpa_pkg and buddy_page_allocator
`timescale 1ns / 1ps

module tb;

	localparam int LEVELS = bpa_pkg::TREE_LEVELS_DEF;
	localparam int PSHIFT = bpa_pkg::PAGE_SHIFT_DEF;
	localparam int MAXPG  = bpa_pkg::MAX_PAGES_DEF;
	localparam int AW     = bpa_pkg::ADDR_W;
	localparam int NODES  = (1 << LEVELS) - 1;
	localparam logic [AW-1:0] REGION = 40'd1 << (LEVELS - 1 + PSHIFT);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [AW-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	bpa_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bpa_pkg::rsp_t rsp;

	buddy_page_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #6 clk = ~clk;

	logic [2:0] tree [NODES];
	logic [AW-1:0] base_addr;
	bpa_pkg::rsp_t pending_rsp [$];
	bpa_pkg::req_t req_queue [$];
	logic [AW-1:0] live_blocks [$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	bit cfg_done;

	function automatic int node_ix(int lvl, int ix);
		return (1 << lvl) - 1 + ix;
	endfunction

	function automatic bpa_pkg::rsp_t alloc_pages(int pages);
		bpa_pkg::rsp_t r;
		int k, tgt, lvl, ix;
		bit hit;
		r = '0;
		k = 0;
		hit = 0;
		ix = 0;
		if (pages == 0 || pages > MAXPG) begin
			r.status = bpa_pkg::ST_BAD_COUNT;
			return r;
		end
		while ((1 << k) < pages) k++;
		if (k > LEVELS - 1) begin
			r.status = bpa_pkg::ST_BAD_COUNT;
			return r;
		end
		tgt = LEVELS - 1 - k;
		for (lvl = tgt; lvl >= 0 && !hit; lvl--) begin
			for (ix = 0; ix < (1 << lvl); ix++)
				if (tree[node_ix(lvl, ix)] == bpa_pkg::NODE_FREE) begin
					hit = 1;
					break;
				end
			if (hit) break;
		end
		if (!hit) begin
			r.status = bpa_pkg::ST_NO_MEM;
			return r;
		end
		while (lvl < tgt) begin
			tree[node_ix(lvl, ix)] = bpa_pkg::NODE_SPLIT;
			tree[node_ix(lvl + 1, 2 * ix)][bpa_pkg::FLAG_VALID] = 1'b1;
			tree[node_ix(lvl + 1, 2 * ix + 1)][bpa_pkg::FLAG_VALID] = 1'b1;
			lvl++;
			ix = ix << 1;
		end
		tree[node_ix(lvl, ix)][bpa_pkg::FLAG_ALLOC] = 1'b1;
		r.block_addr = base_addr +
			(AW'(ix) << (LEVELS - 1 - lvl + PSHIFT));
		r.status = bpa_pkg::ST_OK;
		return r;
	endfunction

	function automatic bpa_pkg::rsp_t free_block(logic [AW-1:0] addr);
		bpa_pkg::rsp_t r;
		logic [AW-1:0] off, bsize;
		int lvl, ix, me, bud;
		r = '0;
		r.status = bpa_pkg::ST_BAD_ADDR;
		off = addr - base_addr;
		if (off >= REGION) return r;
		lvl = LEVELS - 1;
		ix = int'(off >> PSHIFT);
		forever begin
			bsize = 40'd1 << (LEVELS - 1 - lvl + PSHIFT);
			if ((off & (bsize - 40'd1)) != '0) return r;
			if (tree[node_ix(lvl, ix)][bpa_pkg::FLAG_VALID]) break;
			if (lvl == 0) return r;
			ix = ix >> 1;
			lvl--;
		end
		if (tree[node_ix(lvl, ix)][bpa_pkg::FLAG_SPLIT] ||
			!tree[node_ix(lvl, ix)][bpa_pkg::FLAG_ALLOC])
			return r;
		forever begin
			me = node_ix(lvl, ix);
			tree[me] = bpa_pkg::NODE_FREE;
			if (lvl == 0) break;
			bud = node_ix(lvl, ix ^ 1);
			if (tree[bud][bpa_pkg::FLAG_SPLIT] || tree[bud][bpa_pkg::FLAG_ALLOC]) break;
			tree[bud] = bpa_pkg::NODE_EMPTY;
			tree[me] = bpa_pkg::NODE_EMPTY;
			ix = ix >> 1;
			lvl--;
		end
		r.status = bpa_pkg::ST_OK;
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				if (req.func == bpa_pkg::FUNC_FREE)
					pending_rsp.push_back(free_block(req.free_addr));
				else
					pending_rsp.push_back(alloc_pages(int'(req.page_count)));
			end
			if (!req_valid || req_ready) begin
				if (req_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
					req <= req_queue.pop_front();
					req_valid <= 1'b1;
				end else
					req_valid <= 1'b0;
			end
			rsp_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	// monitor
	always @(posedge clk) begin
		bpa_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t unexpected response addr %h status %0d", $time,
					rsp.block_addr, rsp.status);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.block_addr !== want.block_addr || rsp.status !== want.status) begin
					$display("%0t mismatch expected addr %h status %0d actual addr %h status %0d",
						$time, want.block_addr, want.status, rsp.block_addr, rsp.status);
					errors++;
				end
				if (rsp.status == bpa_pkg::ST_OK && rsp.block_addr != '0)
					live_blocks.push_back(rsp.block_addr);
			end
		end
	end

	function automatic logic [AW-1:0] rand_addr();
		return AW'({$urandom, $urandom});
	endfunction

	task automatic add_alloc(int pages);
		bpa_pkg::req_t r;
		r = '0;
		r.func = bpa_pkg::FUNC_ALLOC;
		r.page_count = bpa_pkg::COUNT_W'(pages);
		r.free_addr = rand_addr();
		req_queue.push_back(r);
	endtask

	task automatic add_free(logic [AW-1:0] addr);
		bpa_pkg::req_t r;
		r.func = bpa_pkg::FUNC_FREE;
		r.page_count = bpa_pkg::COUNT_W'($urandom);
		r.free_addr = addr;
		req_queue.push_back(r);
	endtask

	task automatic drain();
		while (req_queue.size() > 0 || req_valid || pending_rsp.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_base(logic [AW-1:0] v);
		cfg_done = 0;
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		while (!cfg_done) begin
			@(posedge clk);
			if (cfg_valid && cfg_ready) cfg_done = 1;
		end
		cfg_valid <= 1'b0;
		base_addr = v;
	endtask

	task automatic random_phase(int n, logic [AW-1:0] b);
		int sel, p;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 45) begin
				p = $urandom_range(99) < 80 ? $urandom_range(1, 16) : $urandom_range(0, 4095);
				add_alloc(p);
			end else if (sel < 85) begin
				p = $urandom_range(11);
				add_free(b + (AW'($urandom_range(1023 >> p)) << (PSHIFT + p)));
			end else
				add_free(rand_addr());
		end
	endtask

	initial begin
		logic [AW-1:0] bases [4];
		for (int i = 0; i < NODES; i++) tree[i] = bpa_pkg::NODE_EMPTY;
		tree[0] = bpa_pkg::NODE_FREE;
		base_addr = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_base(40'hFF_FFFF_F000);
		// directed
		add_alloc(0);
		add_alloc(1025);
		add_alloc(4095);
		add_alloc(1024);
		add_alloc(1);
		add_free(40'hFF_FFFF_F000);
		add_alloc(1);
		add_free(40'hFF_FFFF_F001);
		add_free(40'hFF_FFFF_F000 + REGION);
		add_free(40'hFF_FFFF_F000);
		add_free(40'hFF_FFFF_F000);
		add_alloc(3);
		add_alloc(512);
		add_alloc(512);
		add_free(40'hFF_FFFF_F000 + 40'h10_0000);
		add_free(40'hFF_FFFF_F000 + 40'h20_0000);
		add_free(40'h0);
		add_free(40'hFF_FFFF_FFFF);
		add_alloc(2048);
		send_idle = 27;
		recv_idle = 70;
		drain();
		bases[0] = '0;
		bases[1] = 40'hFF_FFC0_0000;
		bases[2] = rand_addr() & ~40'hFFF;
		bases[3] = rand_addr();
		for (int ph = 0; ph < 4; ph++) begin
			write_base(bases[ph]);
			send_idle = ph == 1 ? 70 : (ph == 0 ? 27 : 0);
			recv_idle = ph == 1 ? 27 : (ph == 0 ? 70 : 0);
			live_blocks.delete();
			for (int blk = 0; blk < 8; blk++) begin
				random_phase(40, bases[ph]);
				drain();
				live_blocks.shuffle();
				while (live_blocks.size() > 0) add_free(live_blocks.pop_front());
			end
			drain();
		end
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#200ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
